// ===== hw/rtl/pcap_udp_payload_extractor_unit_defines.svh =====
// Assertion macros for the capture extractor RTL.
`ifndef PCAP_UDP_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH
`define PCAP_UDP_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define PCAPU_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pcapu assertion failed");

// Next-cycle implication, reset-qualified.
`define PCAPU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pcapu assertion failed");

`endif

// ===== hw/rtl/pcapu_pkg.sv =====
// Types and constants of the capture payload extractor.
package pcapu_pkg;
	localparam logic [3:0] PH_FILE = 4'd0;
	localparam logic [3:0] PH_DEAD = 4'd1;
	localparam logic [3:0] PH_REC  = 4'd2;
	localparam logic [3:0] PH_LINK = 4'd3;
	localparam logic [3:0] PH_IP   = 4'd4;
	localparam logic [3:0] PH_UDP  = 4'd5;
	localparam logic [3:0] PH_DATA = 4'd6;
	localparam logic [3:0] PH_SUBH = 4'd7;
	localparam logic [3:0] PH_SUBD = 4'd8;
	localparam logic [3:0] PH_SKIP = 4'd9;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MAGIC = 3'd1;
	localparam logic [2:0] ST_LINK  = 3'd2;
	localparam logic [2:0] ST_ETYPE = 3'd3;
	localparam logic [2:0] ST_PROTO = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;
	localparam logic [2:0] ST_IHL   = 3'd6;
	localparam logic [2:0] ST_TRUNC = 3'd7;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam logic [31:0] MAGIC_BIG    = 32'hA1B2C3D4;
	localparam logic [31:0] MAGIC_LITTLE = 32'hD4C3B2A1;
	localparam logic [31:0] LINK_ETHER   = 32'd1;
	localparam logic [31:0] LINK_COOKED  = 32'd113;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;

	// Reciprocals for the fixed divisions of the timestamp.
	localparam logic [25:0] RECIP_675  = 26'd50903316;  // floor(2^35 / 675)
	localparam logic [29:0] RECIP_125  = 30'd549755813; // floor(2^36 / 125)
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        first_of_block;
		logic        last_of_block;
		logic [26:0] timestamp_ms;
		logic [2:0]  status;
	} out_t;

	typedef struct packed {
		logic        clear;
		logic        start;
		logic [31:0] seconds;
		logic [31:0] usec;
	} tod_req_t;
endpackage

// ===== hw/rtl/pcapu_tod.sv =====
// Pipelined time-of-day unit: milliseconds since midnight from seconds and microseconds.
module pcapu_tod
	import pcapu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tod_req_t    req,
	output logic [26:0] tod_ms
);
	logic        v_s1, v_s2, v_s3;
	logic [31:0] sec_s1, usec_s1, sec_s2, usec_s2, t1_s2, t2_s2;
	logic [50:0] p1_s1;
	logic [58:0] p2_s1;
	logic [22:0] q2_s2, qc_s3;
	logic [16:0] r_s3;
	logic [26:0] tod_q;

	logic [15:0] q1;
	logic [22:0] q2;
	logic [32:0] t1_full, t2_full;
	logic [31:0] r0_full, rem_full;
	logic [17:0] r0;
	logic [16:0] r;
	logic [10:0] rem;
	logic [22:0] qc;
	logic [26:0] tod_next;

	assign q1      = p1_s1[50:35];
	assign q2      = p2_s1[58:36];
	assign t1_full = q1 * SEC_PER_DAY;
	assign t2_full = q2 * MS_PER_SEC;

	// The reciprocal quotients may fall one short; one compare corrects each.
	assign r0_full  = sec_s2 - t1_s2;
	assign r0       = r0_full[17:0];
	assign r        = (r0 >= {1'b0, SEC_PER_DAY}) ? 17'(r0 - {1'b0, SEC_PER_DAY}) : r0[16:0];
	assign rem_full = usec_s2 - t2_s2;
	assign rem      = rem_full[10:0];
	assign qc       = (rem >= {1'b0, MS_PER_SEC}) ? q2_s2 + 23'd1 : q2_s2;

	assign tod_next = 27'(r_s3) * 27'(MS_PER_SEC) + {4'd0, qc_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			tod_q <= '0;
		end else if (req.clear) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			tod_q <= '0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				tod_q <= tod_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		sec_s1  <= req.seconds;
		usec_s1 <= req.usec;
		p1_s1   <= req.seconds[31:7] * RECIP_675;
		p2_s1   <= req.usec[31:3] * RECIP_125;
		sec_s2  <= sec_s1;
		usec_s2 <= usec_s1;
		t1_s2   <= t1_full[31:0];
		t2_s2   <= t2_full[31:0];
		q2_s2   <= q2;
		r_s3    <= r;
		qc_s3   <= qc;
	end

	assign tod_ms = tod_q;
endmodule

// ===== hw/rtl/pcapu_parse.sv =====
// Byte-at-a-time parser of the file, record, link, IPv4 and UDP headers.
module pcapu_parse
	import pcapu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_t         word,
	input  logic        sub_mode,
	input  logic [26:0] tod_ms,
	output logic        emit,
	output out_t        result,
	output tod_req_t    tod_req
);
	logic [3:0]  phase_q;
	logic [7:0]  byte_index_q;
	logic [31:0] field_shift_q;
	logic        file_swapped_q;
	logic        link_cooked_q;
	logic [31:0] record_left_q;
	logic [31:0] seconds_q;
	logic [5:0]  ip_header_bytes_q;
	logic [15:0] ip_data_length_q;
	logic [15:0] payload_left_q;
	logic [15:0] sub_record_left_q;

	logic [3:0]  ph;
	logic [7:0]  bi;
	logic [31:0] fsh;
	logic        sw;
	logic        ck;
	logic [31:0] rl;
	logic [31:0] sec;
	logic [5:0]  ihb;
	logic [15:0] idl;
	logic [15:0] pl;
	logic [15:0] srl;

	function automatic logic [31:0] take_file_byte(input logic [1:0] k, input logic [7:0] b,
		input logic swapped, input logic [31:0] acc);
		logic [31:0] v;
		v = (k == 2'd0) ? 32'd0 : acc;
		if (swapped) begin
			v = {v[23:0], b};
		end else begin
			v = v | ({24'd0, b} << {k, 3'b000});
		end
		return v;
	endfunction

	always_comb begin
		logic [7:0]  d;
		logic [7:0]  k;
		logic [7:0]  skip;
		logic [26:0] tnow;
		logic        n;
		logic        done;
		d    = word.data_byte;
		ph   = phase_q;
		bi   = byte_index_q;
		fsh  = field_shift_q;
		sw   = file_swapped_q;
		ck   = link_cooked_q;
		rl   = record_left_q;
		sec  = seconds_q;
		ihb  = ip_header_bytes_q;
		idl  = ip_data_length_q;
		pl   = payload_left_q;
		srl  = sub_record_left_q;
		tnow = tod_ms;
		n    = 1'b0;
		done = 1'b0;
		k    = 8'd0;
		skip = 8'd0;
		result  = '0;
		tod_req = '0;
		tod_req.seconds = seconds_q;
		tod_req.usec    = field_shift_q;

		if (word.file_start) begin
			ph   = PH_FILE;
			bi   = '0;
			fsh  = '0;
			sw   = 1'b0;
			ck   = 1'b0;
			rl   = '0;
			sec  = '0;
			ihb  = '0;
			idl  = '0;
			pl   = '0;
			srl  = '0;
			tnow = '0;
			tod_req.clear = accept;
		end

		if (ph == PH_DEAD) begin
			done = 1'b1;
		end else if (ph == PH_FILE) begin
			done = 1'b1;
			k = bi;
			bi = k + 8'd1;
			if (k < 8'd4) begin
				fsh = (k == 8'd0) ? {24'd0, d} : {fsh[23:0], d};
				if (k == 8'd3) begin
					if (fsh == MAGIC_BIG) begin
						sw = 1'b1;
					end else if (fsh == MAGIC_LITTLE) begin
						sw = 1'b0;
					end else begin
						ph = PH_DEAD;
						bi = k;
						n = 1'b1;
						result.kind = KIND_ERROR;
						result.status = ST_MAGIC;
					end
				end
			end else if (k >= 8'd20) begin
				fsh = take_file_byte(k[1:0], d, sw, fsh);
				if (k == 8'd23) begin
					if (fsh == LINK_ETHER) begin
						ck = 1'b0;
						ph = PH_REC;
						bi = '0;
					end else if (fsh == LINK_COOKED) begin
						ck = 1'b1;
						ph = PH_REC;
						bi = '0;
					end else begin
						ph = PH_DEAD;
						bi = k;
						n = 1'b1;
						result.kind = KIND_ERROR;
						result.status = ST_LINK;
					end
				end
			end
		end else if (ph == PH_REC) begin
			done = 1'b1;
			k = bi;
			bi = k + 8'd1;
			if (k < 8'd12) begin
				fsh = take_file_byte(k[1:0], d, sw, fsh);
			end
			if (k == 8'd3) begin
				sec = fsh;
			end else if (k == 8'd7) begin
				// Seconds and microseconds are both in hand; the pipeline finishes
				// long before the first report of this record can go out.
				tod_req.start = accept;
				tod_req.usec  = fsh;
			end else if (k == 8'd11) begin
				rl = fsh;
			end else if (k == 8'd15) begin
				bi = '0;
				if (rl == 32'd0) begin
					n = 1'b1;
					result.kind = KIND_ERROR;
					result.status = ST_TRUNC;
				end else begin
					ph = PH_LINK;
				end
			end
		end

		if (!done) begin
			if (rl != 32'd0) begin
				rl = rl - 32'd1;
			end
			k = bi;
			case (ph)
				PH_LINK: begin
					skip = ck ? 8'd14 : 8'd12;
					if (k == skip) begin
						fsh = {24'd0, d};
					end else if (k == skip + 8'd1) begin
						if ({fsh[7:0], d} != ETYPE_IPV4) begin
							n = 1'b1;
							ph = PH_SKIP;
							result.kind = KIND_ERROR;
							result.status = ST_ETYPE;
						end else begin
							ph = PH_IP;
							k = 8'hFF;
						end
					end
					bi = k + 8'd1;
				end
				PH_IP: begin
					if (k == 8'd0) begin
						ihb = {d[3:0], 2'b00};
						if (ihb < 6'd20) begin
							n = 1'b1;
							ph = PH_SKIP;
							result.kind = KIND_ERROR;
							result.status = ST_IHL;
						end
					end else if (k == 8'd2) begin
						fsh = {24'd0, d};
					end else if (k == 8'd3) begin
						idl = {fsh[7:0], d};
					end else if (k == 8'd9) begin
						if (d != PROTO_UDP) begin
							n = 1'b1;
							ph = PH_SKIP;
							result.kind = KIND_ERROR;
							result.status = ST_PROTO;
						end
					end
					if (!n && (({1'b0, k} + 9'd1) == {3'd0, ihb})) begin
						if (idl < {10'd0, ihb}) begin
							n = 1'b1;
							ph = PH_SKIP;
							result.kind = KIND_ERROR;
							result.status = ST_LEN;
						end else begin
							idl = idl - {10'd0, ihb};
							ph = PH_UDP;
							k = 8'hFF;
						end
					end
					bi = k + 8'd1;
				end
				PH_UDP: begin
					if (k == 8'd4) begin
						fsh = {24'd0, d};
					end else if (k == 8'd5) begin
						fsh = {16'd0, fsh[7:0], d};
					end else if (k == 8'd7) begin
						if (fsh[15:0] != idl || fsh[15:0] < 16'd8) begin
							n = 1'b1;
							ph = PH_SKIP;
							result.kind = KIND_ERROR;
							result.status = ST_LEN;
						end else begin
							pl = fsh[15:0] - 16'd8;
							if ({16'd0, pl} > rl) begin
								n = 1'b1;
								ph = PH_SKIP;
								result.kind = KIND_ERROR;
								result.status = ST_TRUNC;
							end else if (pl == 16'd0) begin
								ph = PH_SKIP;
							end else begin
								ph = sub_mode ? PH_SUBH : PH_DATA;
							end
							k = 8'hFF;
						end
					end
					bi = k + 8'd1;
				end
				PH_DATA: begin
					if (pl != 16'd0) begin
						pl = pl - 16'd1;
					end
					n = 1'b1;
					result.kind = KIND_DATA;
					result.payload_byte = d;
					result.first_of_block = (k == 8'd0);
					result.last_of_block = (pl == 16'd0);
					result.status = ST_OK;
					bi = 8'd1;
					if (pl == 16'd0) begin
						ph = PH_SKIP;
					end
				end
				PH_SUBH: begin
					if (pl != 16'd0) begin
						pl = pl - 16'd1;
					end
					if (k == 8'd0) begin
						fsh = {24'd0, d};
					end else if (k == 8'd1) begin
						fsh = {16'd0, fsh[7:0], d};
					end
					if (k >= 8'd5) begin
						if (fsh[15:0] < 16'd6 ||
							{1'b0, fsh[15:0]} > ({1'b0, pl} + 17'd6)) begin
							ph = PH_SKIP;
						end else begin
							srl = fsh[15:0] - 16'd6;
							bi = '0;
							if (srl != 16'd0) begin
								ph = PH_SUBD;
							end else if (pl == 16'd0) begin
								ph = PH_SKIP;
							end else begin
								ph = PH_SUBH;
							end
						end
					end else if (pl == 16'd0) begin
						ph = PH_SKIP;
					end else begin
						bi = k + 8'd1;
					end
				end
				PH_SUBD: begin
					if (pl != 16'd0) begin
						pl = pl - 16'd1;
					end
					if (srl != 16'd0) begin
						srl = srl - 16'd1;
					end
					n = 1'b1;
					result.kind = KIND_DATA;
					result.payload_byte = d;
					result.first_of_block = (k == 8'd0);
					result.last_of_block = (srl == 16'd0);
					result.status = ST_OK;
					bi = 8'd1;
					if (srl == 16'd0) begin
						if (pl == 16'd0) begin
							ph = PH_SKIP;
						end else begin
							ph = PH_SUBH;
							bi = '0;
						end
					end
				end
				default: begin
				end
			endcase

			// End of the record: a header cut short is reported once.
			if (rl == 32'd0) begin
				if (!n && (ph == PH_LINK || ph == PH_IP || ph == PH_UDP)) begin
					n = 1'b1;
					result.kind = KIND_ERROR;
					result.status = ST_TRUNC;
				end
				ph = PH_REC;
				bi = '0;
			end
		end

		result.timestamp_ms = (result.kind == KIND_ERROR && result.status == ST_MAGIC) ||
			(result.kind == KIND_ERROR && result.status == ST_LINK) ? 27'd0 : tnow;
		emit = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_FILE;
			byte_index_q      <= '0;
			field_shift_q     <= '0;
			file_swapped_q    <= 1'b0;
			link_cooked_q     <= 1'b0;
			record_left_q     <= '0;
			seconds_q         <= '0;
			ip_header_bytes_q <= '0;
			ip_data_length_q  <= '0;
			payload_left_q    <= '0;
			sub_record_left_q <= '0;
		end else if (accept) begin
			phase_q           <= ph;
			byte_index_q      <= bi;
			field_shift_q     <= fsh;
			file_swapped_q    <= sw;
			link_cooked_q     <= ck;
			record_left_q     <= rl;
			seconds_q         <= sec;
			ip_header_bytes_q <= ihb;
			ip_data_length_q  <= idl;
			payload_left_q    <= pl;
			sub_record_left_q <= srl;
		end
	end
endmodule

// ===== hw/rtl/pcapu_out.sv =====
// Result register between the parser and the output channel.
module pcapu_out
	import pcapu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  out_t result,
	output logic full,
	input  logic res_stall,
	output logic res_valid,
	output out_t res_word
);
	logic valid_q;
	out_t word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result;
		end
	end

	// A held word that will not leave this cycle blocks the input side.
	assign full      = valid_q && res_stall;
	assign res_valid = valid_q;
	assign res_word  = word_q;
endmodule

// ===== hw/rtl/pcap_udp_payload_extractor_unit.sv =====
// Capture payload extractor: one capture byte per word in, at most one result word out.
// A result word is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the result channel is not stalled.
// The timestamp pipeline runs through stages s1, s2, s3 and then its output register.
// Reset (arst_n low, asynchronous) returns the parser to the file header and clears mode.
`include "pcap_udp_payload_extractor_unit_defines.svh"
module pcap_udp_payload_extractor_unit
	import pcapu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  in_t  src_word,
	output logic res_valid,
	input  logic res_stall,
	output out_t res_word,
	input  logic cfg_we,
	input  logic cfg_wdata
);
	logic        sub_mode_q;
	logic        accept;
	logic        emit;
	logic        full;
	out_t        result;
	tod_req_t    tod_req;
	logic [26:0] tod_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_mode_q <= 1'b0;
		end else if (cfg_we) begin
			sub_mode_q <= cfg_wdata;
		end
	end

	assign src_stall = full;
	assign accept    = src_valid && !full;

	pcapu_tod u_tod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tod_req),
		.tod_ms (tod_ms)
	);

	pcapu_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (src_word),
		.sub_mode (sub_mode_q),
		.tod_ms   (tod_ms),
		.emit     (emit),
		.result   (result),
		.tod_req  (tod_req)
	);

	pcapu_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && emit),
		.result    (result),
		.full      (full),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	`PCAPU_ASSERT_NOW(a_stall_needs_word, clk, arst_n, src_stall, res_valid)
	`PCAPU_ASSERT_NOW(a_error_clean, clk, arst_n, res_valid && res_word.kind == KIND_ERROR,
		res_word.payload_byte == 8'd0 && !res_word.first_of_block && !res_word.last_of_block)
	`PCAPU_ASSERT_NOW(a_data_ok, clk, arst_n, res_valid && res_word.kind == KIND_DATA,
		res_word.status == ST_OK)
	`PCAPU_ASSERT_NEXT(a_emit_shows, clk, arst_n, accept && emit, res_valid)
endmodule
